// ===== design/psa_pkg.sv =====
// Shared types and codes for the paged slot allocator.
// No dependencies; imported by the top level.
`default_nettype none

package psa_pkg;

  // command codes carried on in_tuser
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_CHECK  = 2'd2;

  // status codes carried on out_tuser
  localparam logic [1:0] STS_OK        = 2'd0;
  localparam logic [1:0] STS_BAD_ID    = 2'd1;
  localparam logic [1:0] STS_NO_RECORD = 2'd2;
  localparam logic [1:0] STS_FULL      = 2'd3;

  // register word index
  localparam logic REG_SLOTS_PER_PAGE = 1'b0;

  localparam int unsigned DEF_MAX_PAGES = 256;
  localparam int unsigned DEF_MAX_SLOTS = 64;
  localparam logic [6:0]  SLOTS_RESET   = 7'd64;

  localparam int unsigned PAGE_W  = 8;
  localparam int unsigned SLOT_W  = 6;
  localparam int unsigned COUNT_W = 7;
  localparam int unsigned PIU_W   = 9;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

endpackage

`default_nettype wire

// ===== design/paged_slot_allocator.sv =====
// Paged slot allocator top level: command stream in, one result per command out.
// Depends on psa_pkg and psa_ram (page table: free bitmap, free count, next link).
//
// Each command is taken in idle, where the accept cycle issues a read of the
// page table entry (the free-list head for insert, the addressed page
// otherwise); the execute state then modifies the entry, writes it back and
// loads the result register. A new command is accepted only once the block is
// back in idle, so it is not taken before the last one is through; a result
// left waiting in the output register holds the block in the execute state.
// The page table needs no clearing pass after reset: only entries of pages
// already opened are ever used. slots_per_page lives at byte address 0 of the
// register port; 0 acts as 1 and values above MAX_SLOTS act as MAX_SLOTS.
`default_nettype none

module paged_slot_allocator
  import psa_pkg::*;
#(
  parameter int unsigned MAX_PAGES = DEF_MAX_PAGES,
  parameter int unsigned MAX_SLOTS = DEF_MAX_SLOTS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // command channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [7:0] page_number, [13:8] slot_number
  input  wire logic [1:0]  in_tuser,   // [1:0] cmd
  // result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [15:0] out_tdata,  // [7:0] result_page, [13:8] result_slot
  output logic      [1:0]  out_tuser,  // [1:0] status
  // register port
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready
);

  localparam int unsigned PAGE_DEPTH = (MAX_PAGES < 256) ? MAX_PAGES : 256;
  localparam int unsigned AW         = $clog2(PAGE_DEPTH);
  localparam int unsigned EW         = MAX_SLOTS + COUNT_W + PAGE_W;
  localparam logic [PIU_W-1:0]   PAGE_LIMIT = PIU_W'(PAGE_DEPTH);
  localparam logic [COUNT_W-1:0] CAP_MAX    = COUNT_W'(MAX_SLOTS);

  // ---------------- register port ----------------
  logic [COUNT_W-1:0] slots_r, slots_nxt;

  assign cfg_pready = 1'b1;

  always_comb begin
    slots_nxt = slots_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
        cfg_paddr[2] == REG_SLOTS_PER_PAGE) begin
      slots_nxt = cfg_pwdata[COUNT_W-1:0];
    end
    cfg_prdata = '0;
    if (cfg_paddr[2] == REG_SLOTS_PER_PAGE) begin
      cfg_prdata = {{(32-COUNT_W){1'b0}}, slots_r};
    end
  end

  // ---------------- control and payload registers ----------------
  state_t state_r, state_nxt;

  logic [1:0]         cmd_r;
  logic [PAGE_W-1:0]  pg_r;
  logic [SLOT_W-1:0]  sl_r;
  logic [AW-1:0]      addr_r, rd_addr;

  logic [PAGE_W-1:0]  head_r, head_nxt;
  logic [PIU_W-1:0]   piu_r, piu_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         out_status_r, out_status_nxt;
  logic [PAGE_W-1:0]  out_page_r, out_page_nxt;
  logic [SLOT_W-1:0]  out_slot_r, out_slot_nxt;

  logic               accept;
  logic               finish;

  assign in_tready  = (state_r == ST_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {2'b00, out_slot_r, out_page_r};

  // read address: free-list head for insert, addressed page otherwise
  always_comb begin
    if (state_r == ST_IDLE) begin
      rd_addr = (in_tuser == CMD_INSERT) ? head_r[AW-1:0] : in_tdata[AW-1:0];
    end else begin
      rd_addr = addr_r;
    end
  end

  // ---------------- page table ----------------
  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  logic [EW-1:0]  mem_wdata;
  logic [EW-1:0]  mem_rdata;

  psa_ram #(
    .WIDTH (EW),
    .DEPTH (PAGE_DEPTH)
  ) u_page_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (rd_addr),
    .rdata (mem_rdata)
  );

  // ---------------- execute datapath ----------------
  logic [MAX_SLOTS-1:0] e_bits;
  logic [COUNT_W-1:0]   e_cnt;
  logic [PAGE_W-1:0]    e_next;
  logic [COUNT_W-1:0]   cap;
  logic [MAX_SLOTS-1:0] cap_mask;
  logic [MAX_SLOTS-1:0] sl_onehot;

  logic                 open_new;
  logic [PAGE_W-1:0]    ins_page;
  logic [MAX_SLOTS-1:0] ins_bits, ins_avail, ins_low;
  logic [COUNT_W-1:0]   ins_cnt, ins_cnt_dec;
  logic [PAGE_W-1:0]    ins_next;
  logic [SLOT_W-1:0]    ins_idx;
  logic                 bad_id;
  logic                 slot_free;

  assign {e_next, e_cnt, e_bits} = mem_rdata;

  always_comb begin
    if (slots_r == '0) begin
      cap = COUNT_W'(1);
    end else if (slots_r > CAP_MAX) begin
      cap = CAP_MAX;
    end else begin
      cap = slots_r;
    end
    for (int i = 0; i < MAX_SLOTS; i++) begin
      cap_mask[i]  = (COUNT_W'(i) < cap);
      sl_onehot[i] = (SLOT_W'(i) == sl_r);
    end
  end

  // insert: pick the entry, isolate its lowest free slot
  always_comb begin
    open_new  = (head_r == '0);
    ins_page  = open_new ? piu_r[PAGE_W-1:0] : head_r;
    ins_bits  = open_new ? cap_mask : e_bits;
    ins_cnt   = open_new ? cap : e_cnt;
    ins_next  = open_new ? '0 : e_next;
    ins_avail = ins_bits & cap_mask;
    ins_low   = ins_avail & (~ins_avail + MAX_SLOTS'(1));
    ins_cnt_dec = (ins_cnt == '0) ? '0 : ins_cnt - COUNT_W'(1);
    for (int b = 0; b < SLOT_W; b++) begin
      ins_idx[b] = 1'b0;
      for (int i = 0; i < MAX_SLOTS; i++) begin
        if (((i >> b) & 1) == 1) begin
          ins_idx[b] = ins_idx[b] | ins_low[i];
        end
      end
    end
  end

  always_comb begin
    bad_id = (cmd_r != CMD_DELETE && cmd_r != CMD_CHECK) || pg_r == '0 ||
             {1'b0, pg_r} >= piu_r || {1'b0, sl_r} >= cap;
    slot_free = |(e_bits & sl_onehot);
  end

  // ---------------- FSM, writeback, result ----------------
  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    piu_nxt        = piu_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_page_nxt   = out_page_r;
    out_slot_nxt   = out_slot_r;
    mem_we         = 1'b0;
    mem_waddr      = addr_r;
    mem_wdata      = mem_rdata;
    finish         = 1'b0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!out_valid_r || out_tready) begin
          finish         = 1'b1;
          state_nxt      = ST_IDLE;
          out_valid_nxt  = 1'b1;
          out_status_nxt = STS_OK;
          out_page_nxt   = pg_r;
          out_slot_nxt   = sl_r;
          if (cmd_r == CMD_INSERT) begin
            if (open_new && piu_r >= PAGE_LIMIT) begin
              out_status_nxt = STS_FULL;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = ins_page[AW-1:0];
              if (open_new) begin
                piu_nxt = piu_r + PIU_W'(1);
              end
              if (ins_avail == '0) begin
                // head page has no slot under the current capacity: drop it
                head_nxt       = ins_next;
                mem_wdata      = {PAGE_W'(0), ins_cnt, ins_bits};
                out_status_nxt = STS_FULL;
              end else begin
                out_page_nxt = ins_page;
                out_slot_nxt = ins_idx;
                if (ins_cnt_dec == '0) begin
                  head_nxt  = ins_next;
                  mem_wdata = {PAGE_W'(0), ins_cnt_dec, ins_bits & ~ins_low};
                end else begin
                  head_nxt  = ins_page;
                  mem_wdata = {ins_next, ins_cnt_dec, ins_bits & ~ins_low};
                end
              end
            end
          end else if (bad_id) begin
            out_status_nxt = STS_BAD_ID;
          end else if (slot_free) begin
            out_status_nxt = STS_NO_RECORD;
          end else if (cmd_r == CMD_DELETE) begin
            mem_we = 1'b1;
            // a full page goes back on the head of the free list
            mem_wdata = {(e_cnt == '0) ? head_r : e_next,
                         (e_cnt == {COUNT_W{1'b1}}) ? e_cnt : e_cnt + COUNT_W'(1),
                         e_bits | sl_onehot};
            if (e_cnt == '0) begin
              head_nxt = pg_r;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      slots_r     <= SLOTS_RESET;
      head_r      <= '0;
      piu_r       <= PIU_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      slots_r     <= slots_nxt;
      head_r      <= head_nxt;
      piu_r       <= piu_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r  <= in_tuser;
      pg_r   <= in_tdata[7:0];
      sl_r   <= in_tdata[13:8];
      addr_r <= rd_addr;
    end
    out_status_r <= out_status_nxt;
    out_page_r   <= out_page_nxt;
    out_slot_r   <= out_slot_nxt;
  end

  // ---------------- assertions ----------------
  a_piu_range: assert property (@(posedge clk) disable iff (!rst_n)
    piu_r >= PIU_W'(1) && piu_r <= PAGE_LIMIT)
    else $error("pages in use out of range");

  a_head_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, head_r} < piu_r)
    else $error("free list head points at an unopened page");

  a_we_exec: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == ST_EXEC && finish))
    else $error("page table written outside execute");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == ST_EXEC)
    else $error("accepted command not executed");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(finish))
    else $error("result appeared without an executed command");

endmodule

`default_nettype wire

// ===== design/psa_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module psa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== tb/sv/psa_alloc_scoreboard.sv =====
`timescale 1ns / 1ps
// Scoreboard for the paged slot allocator bench: a behavioral copy of the page
// tables that predicts each result, and the in-order result check.
// Depends on psa_pkg for the command and status codes and the default sizes.

package psa_tb_pkg;
  import psa_pkg::*;

  localparam int unsigned PAGE_LIMIT = (DEF_MAX_PAGES < 256) ? DEF_MAX_PAGES : 256;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] page;
    logic [5:0] slot;
  } alloc_result_t;

  class slot_alloc_scoreboard;
    logic [63:0]   free_map  [DEF_MAX_PAGES];
    logic [6:0]    free_cnt  [DEF_MAX_PAGES];
    logic [7:0]    next_link [DEF_MAX_PAGES];
    logic [7:0]    head;
    logic [8:0]    pages_open;
    logic [6:0]    slots_reg;
    alloc_result_t pending_q[$];
    int            errors;

    function new();
      for (int i = 0; i < DEF_MAX_PAGES; i++) begin
        free_map[i]  = '0;
        free_cnt[i]  = '0;
        next_link[i] = '0;
      end
      head       = '0;
      pages_open = 9'd1;
      slots_reg  = SLOTS_RESET;
      errors     = 0;
    endfunction

    // register value clamped to 1..MAX_SLOTS
    function int unsigned capacity();
      int unsigned c;
      c = slots_reg;
      if (c < 1) c = 1;
      if (c > DEF_MAX_SLOTS) c = DEF_MAX_SLOTS;
      return c;
    endfunction

    function logic [63:0] slot_mask(int unsigned c);
      return (c >= 64) ? {64{1'b1}} : ((64'd1 << c) - 64'd1);
    endfunction

    function alloc_result_t predict(logic [1:0] cmd, logic [7:0] pg, logic [5:0] sl);
      int unsigned   cap;
      logic [63:0]   bits;
      logic [7:0]    p;
      int            lowest;
      alloc_result_t res;
      cap = capacity();
      res.status = STS_OK;
      res.page   = pg;
      res.slot   = sl;
      if (cmd == CMD_INSERT) begin
        if (head == 8'd0) begin
          if (pages_open >= PAGE_LIMIT) begin
            res.status = STS_FULL;
            return res;
          end
          p = pages_open[7:0];
          free_map[p]  = slot_mask(cap);
          free_cnt[p]  = 7'(cap);
          next_link[p] = '0;
          head = p;
          pages_open = pages_open + 9'd1;
        end
        p = head;
        bits = free_map[p] & slot_mask(cap);
        lowest = -1;
        for (int i = int'(cap) - 1; i >= 0; i--)
          if (bits[i]) lowest = i;
        // head page has nothing free below the current capacity: drop it
        if (lowest < 0) begin
          head = next_link[p];
          next_link[p] = '0;
          res.status = STS_FULL;
          return res;
        end
        free_map[p][lowest] = 1'b0;
        if (free_cnt[p] > 7'd0) free_cnt[p] = free_cnt[p] - 7'd1;
        if (free_cnt[p] == 7'd0) begin
          head = next_link[p];
          next_link[p] = '0;
        end
        res.page = p;
        res.slot = 6'(lowest);
        return res;
      end
      if ((cmd != CMD_DELETE && cmd != CMD_CHECK) || pg == 8'd0 || pg >= pages_open ||
          sl >= cap) begin
        res.status = STS_BAD_ID;
        return res;
      end
      if (free_map[pg][sl]) begin
        res.status = STS_NO_RECORD;
        return res;
      end
      if (cmd == CMD_DELETE) begin
        free_map[pg][sl] = 1'b1;
        // page was full: relink at the head
        if (free_cnt[pg] == 7'd0) begin
          next_link[pg] = head;
          head = pg;
        end
        if (free_cnt[pg] < 7'd127) free_cnt[pg] = free_cnt[pg] + 7'd1;
      end
      return res;
    endfunction

    function void note_command(logic [1:0] cmd, logic [7:0] pg, logic [5:0] sl);
      pending_q.push_back(predict(cmd, pg, sl));
    endfunction

    function void check_result(logic [1:0] st, logic [7:0] pg, logic [5:0] sl);
      alloc_result_t want;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result: status %0d page %0d slot %0d", $time, st, pg, sl);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      if (st !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, st);
        errors++;
      end
      if (pg !== want.page) begin
        $display("%0t: result_page expected %0d actual %0d", $time, want.page, pg);
        errors++;
      end
      if (sl !== want.slot) begin
        $display("%0t: result_slot expected %0d actual %0d", $time, want.slot, sl);
        errors++;
      end
    endfunction
  endclass

endpackage

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// Top-level bench for paged_slot_allocator: directed and random command streams
// under random stalls, across several capacity settings.
// Depends on psa_pkg, psa_tb_pkg (scoreboard) and the allocator RTL.

module tb;
  import psa_pkg::*;
  import psa_tb_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int         CYCLE_LIMIT = 400000;
  localparam int         NUM_PHASES = 6;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;   // [7:0] page_number, [13:8] slot_number
  logic [1:0]  in_tuser = '0;   // [1:0] cmd
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;       // [7:0] result_page, [13:8] result_slot
  logic [1:0]  out_tuser;       // [1:0] status
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  slot_alloc_scoreboard sb = new();
  int   cycles = 0;
  logic quiet = 1'b0;   // stretch with no stalls on either side
  int   hold_left = 0;

  paged_slot_allocator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if ($urandom_range(0, 299) == 0) quiet <= ~quiet;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // result side backpressure
  always @(negedge clk) begin : ready_gen
    int r;
    r = $urandom_range(0, 99);
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (quiet || r < 75) begin
      out_tready <= 1'b1;
    end else if (r < 95) begin
      out_tready <= 1'b0;
      hold_left = $urandom_range(0, 2);
    end else begin
      out_tready <= 1'b0;
      hold_left = $urandom_range(8, 30);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tuser, out_tdata[7:0], out_tdata[13:8]);
  end

  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // called at a falling edge; returns at a falling edge with tvalid still high
  task automatic send_command(input logic [1:0] cmd, input logic [7:0] pg,
                              input logic [5:0] sl);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {2'b00, sl, pg};
    do @(posedge clk); while (!in_tready);
    sb.note_command(cmd, pg, sl);
    @(negedge clk);
  endtask

  // inserts, and mostly well-formed deletes and checks aimed at live pages, some noise
  task automatic pick_command(input int ins_pct, input int del_pct, output logic [1:0] cmd,
                              output logic [7:0] pg, output logic [5:0] sl);
    int r;
    int unsigned cap;
    r   = $urandom_range(0, 99);
    cap = sb.capacity();
    pg  = 8'($urandom);
    sl  = 6'($urandom);
    if (r < ins_pct) begin
      cmd = CMD_INSERT;
    end else if (r < 90) begin
      cmd = (r < ins_pct + del_pct) ? CMD_DELETE : CMD_CHECK;
      for (int t = 0; t < 4; t++) begin
        pg = (sb.pages_open > 9'd1) ? 8'($urandom_range(1, sb.pages_open - 1)) : 8'd1;
        sl = 6'($urandom_range(0, cap - 1));
        if (!sb.free_map[pg][sl]) break;
      end
    end else begin
      cmd = 2'($urandom_range(0, 3));
    end
  endtask

  // called at a falling edge with the block idle
  task automatic write_slots(input logic [6:0] value);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= 3'(REG_SLOTS_PER_PAGE) << 2;
    cfg_pwdata  <= {25'd0, value};
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.slots_reg = value;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin : main
    logic [6:0]  caps [NUM_PHASES];
    int          counts [NUM_PHASES];
    int          ins_w [NUM_PHASES];
    int          del_w [NUM_PHASES];
    logic [1:0]  cmd;
    logic [7:0]  pg;
    logic [5:0]  sl;
    caps   = '{7'd64, 7'd0, 7'd127, 7'd0, 7'd1, 7'd64};
    caps[3] = 7'($urandom_range(2, 63));
    counts = '{330, 330, 300, 300, 240, 330};
    // the capacity-0 phase is insert heavy so the store runs out of pages
    ins_w  = '{45, 88, 35, 45, 50, 40};
    del_w  = '{30, 2, 35, 30, 25, 30};

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: lowest-slot allocation, reuse, bad-id and no-record rejections
    send_command(CMD_INSERT, 8'd0, 6'd0);
    send_command(CMD_INSERT, 8'd255, 6'd63);
    send_command(CMD_CHECK, 8'd1, 6'd0);
    send_command(CMD_CHECK, 8'd1, 6'd63);
    send_command(CMD_DELETE, 8'd1, 6'd0);
    send_command(CMD_DELETE, 8'd1, 6'd0);
    send_command(CMD_CHECK, 8'd0, 6'd0);
    send_command(CMD_CHECK, 8'd255, 6'd63);
    send_command(CMD_DELETE, 8'd2, 6'd0);
    send_command(CMD_DELETE, 8'd0, 6'd63);
    send_command(CMD_UNUSED, 8'd1, 6'd1);
    send_command(CMD_UNUSED, 8'd255, 6'd63);
    send_command(CMD_INSERT, 8'd170, 6'd42);
    send_command(CMD_INSERT, 8'd85, 6'd21);
    send_command(CMD_DELETE, 8'd1, 6'd1);
    send_command(CMD_CHECK, 8'd1, 6'd1);
    send_command(CMD_CHECK, 8'd1, 6'd2);
    send_command(CMD_INSERT, 8'd0, 6'd0);
    drain();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_slots(caps[ph]);
      for (int n = 0; n < counts[ph]; n++) begin
        pick_command(ins_w[ph], del_w[ph], cmd, pg, sl);
        send_command(cmd, pg, sl);
      end
      drain();
    end

    repeat (10) @(posedge clk);
    if (sb.errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// ===== files.f =====
design/psa_pkg.sv
design/psa_ram.sv
design/paged_slot_allocator.sv
tb/sv/psa_alloc_scoreboard.sv
tb/sv/tb.sv
